[rtl/stvb_pkg.sv]
// ----------------------------------------------------------------------------
// stvb_pkg
// shared types and constants for the stepper tone voice bank
// ----------------------------------------------------------------------------
package stvb_pkg;

    // bank size and sweep length
    localparam int CHANNELS        = 5;
    localparam int STEPS_PER_SWEEP = 120;

    // derived widths
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_W  = 5;
    localparam int SHOWN  = (CHANNELS < OUT_W) ? CHANNELS : OUT_W;
    localparam int PER_W  = 24;
    localparam int ELA_W  = 16;
    localparam int CNT_W  = 7;

    localparam logic [PER_W-1:0] ACC_MAX = {PER_W{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PLAY  = 2'd1,
        OP_STOP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_DONE
    } state_t;

    // per-channel record
    typedef struct packed {
        logic             armed;
        logic [PER_W-1:0] half_period;
        logic [PER_W-1:0] accumulator;
        logic             phase_bit;
        logic [CNT_W-1:0] step_count;
        logic             direction_bit;
        logic             step_line;
        logic             dir_line;
    } voice_t;

    // write flags from the shared unit
    typedef struct packed {
        logic step;
        logic dir;
    } wrote_t;

endpackage

[rtl/stepper_tone_voice_bank_top.sv]
// ----------------------------------------------------------------------------
// stepper_tone_voice_bank_top
// bank of square-wave step/direction tone channels behind stream ports
// ----------------------------------------------------------------------------
// usage
//   the slave stream takes one command per transfer: tick, play, stop or
//   clear. every command gives exactly one result transfer on the master
//   stream with the step and direction levels of channels 0 to 4 and the
//   lines written by that command.
//   a tick walks the channels one per cycle through a single shared
//   add/saturate/compare unit; play, stop and clear touch one channel.
//   the channel walk sets the rate.
//   s_axis_tready is high only while the sequencer waits for a command.
//   results sit in an output register: a new command is taken while an
//   earlier result still waits, and the sequencer holds its finished
//   result until that register frees up, so a stalled receiver only
//   delays, never drops.
//   reset clears every channel (disarmed, zero period, lines low) and
//   empties the output register.
// ----------------------------------------------------------------------------
module stepper_tone_voice_bank_top
    import stvb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], channel[4:2], period[28:5], elapsed[44:29], zero pad
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // step_levels[4:0], dir_levels[9:5], step_written[14:10],
    // dir_written[19:15], zero pad
    output logic [23:0] m_axis_tdata
);

    // sequencer state
    state_t state_reg, state_next;

    // latched command
    op_t              op_reg;
    logic [2:0]       ch_reg;
    logic [PER_W-1:0] period_reg;
    logic [ELA_W-1:0] elapsed_reg;

    // channel pointer for the walk
    logic [CH_W-1:0] idx_reg, idx_next;

    // written masks gathered during the walk
    logic [OUT_W-1:0] step_w_reg, step_w_next;
    logic [OUT_W-1:0] dir_w_reg,  dir_w_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg,  out_data_next;

    // shared unit and state store
    voice_t              cur_voice, nxt_voice;
    wrote_t              wrote;
    logic                wr_en;
    logic [CHANNELS-1:0] step_lines, dir_lines;

    logic in_xfer;
    logic ch_in_range;
    logic last_ch;
    logic out_free;
    logic load_out;
    logic [OUT_W-1:0] step_lv, dir_lv;

    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign ch_in_range = (32'(ch_reg) < CHANNELS);
    assign last_ch     = (32'(idx_reg) == CHANNELS - 1);
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign load_out    = (state_reg == ST_DONE) && out_free;

    // a tick writes every channel; other commands only an existing one
    assign wr_en = (state_reg == ST_WORK) && ((op_reg == OP_TICK) || ch_in_range);

    stvb_voice_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .idx        (idx_reg),
        .wr_data    (nxt_voice),
        .rd_data    (cur_voice),
        .step_lines (step_lines),
        .dir_lines  (dir_lines)
    );

    stvb_voice_unit u_unit
    (
        .op      (op_reg),
        .period  (period_reg),
        .elapsed (elapsed_reg),
        .cur     (cur_voice),
        .nxt     (nxt_voice),
        .wrote   (wrote)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if ((op_reg != OP_TICK) || last_ch)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_axis_tready = 1'b0;
        idx_next      = idx_reg;
        step_w_next   = step_w_reg;
        dir_w_next    = dir_w_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                step_w_next   = '0;
                dir_w_next    = '0;
                // tick starts the walk at channel 0, others go straight to theirs
                if (op_t'(s_axis_tdata[1:0]) == OP_TICK)
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = CH_W'(s_axis_tdata[4:2]);
                end
            end
            ST_WORK:
            begin
                if (wr_en)
                begin
                    for (int j = 0; j < SHOWN; j++)
                    begin
                        if (idx_reg == CH_W'(j))
                        begin
                            step_w_next[j] = step_w_reg[j] | wrote.step;
                            dir_w_next[j]  = dir_w_reg[j]  | wrote.dir;
                        end
                    end
                end
                if ((op_reg == OP_TICK) && !last_ch)
                begin
                    idx_next = idx_reg + CH_W'(1);
                end
            end
            ST_DONE:
            begin
                s_axis_tready = 1'b0;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // line levels of the visible channels
    always_comb
    begin
        step_lv = '0;
        dir_lv  = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            step_lv[i] = step_lines[i];
            dir_lv[i]  = dir_lines[i];
        end
    end

    // output register: load when the result is ready, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, dir_w_reg, step_w_reg, dir_lv, step_lv};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            step_w_reg    <= '0;
            dir_w_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_w_reg    <= step_w_next;
            dir_w_reg     <= dir_w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg      <= op_t'(s_axis_tdata[1:0]);
            ch_reg      <= s_axis_tdata[4:2];
            period_reg  <= s_axis_tdata[28:5];
            elapsed_reg <= s_axis_tdata[44:29];
        end
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    // the walk pointer never leaves the bank during a tick
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WORK) && (op_reg == OP_TICK) |-> (32'(idx_reg) < CHANNELS))
        else $error("channel pointer beyond bank");

    // a direction write only ever comes with a step write
    a_dir_with_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[19:15] & ~m_axis_tdata[14:10]) == '0))
        else $error("direction written without step");

    // play and stop write no lines
    a_quiet_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && ((op_reg == OP_PLAY) || (op_reg == OP_STOP))
        |-> (step_w_reg == '0) && (dir_w_reg == '0))
        else $error("play or stop reported a line write");

    // an accepted command always starts work next cycle
    a_start_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_WORK))
        else $error("accepted command did not start");

    // a finished result is never overwritten while waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");
`endif

endmodule

[rtl/stvb_voice_unit.sv]
// ----------------------------------------------------------------------------
// stvb_voice_unit
// shared update unit: applies one operation to one channel record
// ----------------------------------------------------------------------------
module stvb_voice_unit
    import stvb_pkg::*;
(
    input  op_t              op,
    input  logic [PER_W-1:0] period,
    input  logic [ELA_W-1:0] elapsed,
    input  voice_t           cur,
    output voice_t           nxt,
    output wrote_t           wrote
);

    logic [PER_W:0]   sum;
    logic [PER_W-1:0] acc_sat;
    logic [CNT_W-1:0] cnt_inc;

    // saturating add, then compare against the half-period
    assign sum     = {1'b0, cur.accumulator} + {{(PER_W+1-ELA_W){1'b0}}, elapsed};
    assign acc_sat = sum[PER_W] ? ACC_MAX : sum[PER_W-1:0];
    assign cnt_inc = cur.step_count + CNT_W'(1);

    always_comb
    begin
        nxt   = cur;
        wrote = '0;
        case (op)
            OP_TICK:
            begin
                if (cur.armed)
                begin
                    nxt.accumulator = acc_sat;
                    if (acc_sat >= cur.half_period)
                    begin
                        nxt.accumulator = '0;
                        nxt.step_line   = cur.phase_bit;
                        nxt.phase_bit   = ~cur.phase_bit;
                        nxt.step_count  = cnt_inc;
                        wrote.step      = 1'b1;
                        if (cnt_inc == CNT_W'(STEPS_PER_SWEEP))
                        begin
                            nxt.step_count    = '0;
                            nxt.dir_line      = cur.direction_bit;
                            nxt.direction_bit = ~cur.direction_bit;
                            wrote.dir         = 1'b1;
                        end
                    end
                end
            end
            OP_PLAY:
            begin
                nxt.armed       = 1'b1;
                nxt.half_period = period;
                nxt.accumulator = period;
            end
            OP_STOP:
            begin
                nxt.armed = 1'b0;
            end
            OP_CLEAR:
            begin
                nxt.armed         = 1'b0;
                nxt.accumulator   = '0;
                nxt.phase_bit     = 1'b0;
                nxt.step_count    = '0;
                nxt.direction_bit = 1'b0;
                nxt.step_line     = 1'b0;
                nxt.dir_line      = 1'b0;
                wrote.step        = 1'b1;
                wrote.dir         = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

[rtl/stvb_voice_regs.sv]
// ----------------------------------------------------------------------------
// stvb_voice_regs
// per-channel state registers with one write and one read port
// ----------------------------------------------------------------------------
module stvb_voice_regs
    import stvb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [CH_W-1:0]     idx,
    input  voice_t              wr_data,
    output voice_t              rd_data,
    output logic [CHANNELS-1:0] step_lines,
    output logic [CHANNELS-1:0] dir_lines
);

    voice_t bank_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                bank_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            bank_reg[idx] <= wr_data;
        end
    end

    assign rd_data = bank_reg[idx];

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            step_lines[i] = bank_reg[i].step_line;
            dir_lines[i]  = bank_reg[i].dir_line;
        end
    end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stepper tone voice bank
// ----------------------------------------------------------------------------
// commands go in on the slave stream from a queue of pending commands filled
// at time zero. a bit-accurate model of the channel bank is updated on every
// accepted command and records the level/written flags it expects. each
// transfer on the master stream is checked field by field against the oldest
// expectation. a short directed run covers the corner cases first. random
// blocks follow: each one drains the bank, starts a long-running channel and
// then mixes mostly ticks with play/stop/clear traffic, out-of-range
// channels among it. both streams idle in random bursts. the receiver holds
// off once for a long stretch, and some commands wait until all results
// are back.
// ----------------------------------------------------------------------------
module tb;
    import stvb_pkg::*;

    localparam int ITEMS      = 1450;   // total commands
    localparam int CALM_TAIL  = 100;    // last commands sent with no idling
    localparam int HOLD_AT    = 300;    // accepted commands before the long hold
    localparam int HOLD_LEN   = 400;    // cycles of the long receiver hold

    // one command as the bench sees it
    typedef struct {
        op_t              op;
        logic [2:0]       chan;
        logic [PER_W-1:0] period;
        logic [ELA_W-1:0] elapsed;
        bit               drain;        // wait for all results before sending
    } tone_cmd_t;

    // one result transfer
    typedef struct {
        logic [OUT_W-1:0] step_lv;
        logic [OUT_W-1:0] dir_lv;
        logic [OUT_W-1:0] step_wr;
        logic [OUT_W-1:0] dir_wr;
    } tone_res_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    tone_cmd_t   cmd_q[$];              // commands not yet offered
    tone_res_t   level_exp_q[$];        // expected results, oldest first
    int          mismatch_cnt  = 0;
    int          in_count      = 0;     // accepted commands
    logic        in_xfer       = 1'b0;  // command transfer at the last rising edge
    int unsigned send_gap      = 0;
    int unsigned rx_stall      = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    bit          calm;

    // model of the channel bank
    logic             ch_armed  [CHANNELS];
    logic [PER_W-1:0] ch_half   [CHANNELS];
    logic [PER_W-1:0] ch_acc    [CHANNELS];
    logic             ch_phase  [CHANNELS];
    logic [CNT_W-1:0] ch_count  [CHANNELS];
    logic             ch_dirbit [CHANNELS];
    logic             ch_step_ln[CHANNELS];
    logic             ch_dir_ln [CHANNELS];

    stepper_tone_voice_bank_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // no idling in every fourth stretch of ~100 commands and in the tail
    assign calm = ((in_count / 97) % 4 == 3) || (cmd_q.size() < CALM_TAIL);

    // ------------------------------------------------------------------------
    // bank model: apply one command, return the levels and written lines
    // ------------------------------------------------------------------------
    function automatic tone_res_t bank_step(input tone_cmd_t c);
        tone_res_t            r;
        logic [PER_W:0]       sum;
        logic [CHANNELS-1:0]  sw;
        logic [CHANNELS-1:0]  dw;
        sw = '0;
        dw = '0;
        if (c.op == OP_TICK)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (ch_armed[i])
                begin
                    // saturating accumulate
                    sum = {1'b0, ch_acc[i]} + (PER_W + 1)'(c.elapsed);
                    if (sum > {1'b0, ACC_MAX})
                        ch_acc[i] = ACC_MAX;
                    else
                        ch_acc[i] = sum[PER_W-1:0];
                    if (ch_acc[i] >= ch_half[i])
                    begin
                        ch_acc[i]     = '0;
                        ch_step_ln[i] = ch_phase[i];
                        ch_phase[i]   = ~ch_phase[i];
                        sw[i]         = 1'b1;
                        ch_count[i]   = ch_count[i] + 1'b1;
                        // end of a sweep flips the direction line
                        if (ch_count[i] == CNT_W'(STEPS_PER_SWEEP))
                        begin
                            ch_count[i]  = '0;
                            ch_dir_ln[i] = ch_dirbit[i];
                            ch_dirbit[i] = ~ch_dirbit[i];
                            dw[i]        = 1'b1;
                        end
                    end
                end
            end
        end
        else if (c.chan < CHANNELS)
        begin
            case (c.op)
                OP_PLAY:
                begin
                    ch_armed[c.chan] = 1'b1;
                    ch_half[c.chan]  = c.period;
                    ch_acc[c.chan]   = c.period;
                end
                OP_STOP:
                    ch_armed[c.chan] = 1'b0;
                default:
                begin
                    // clear keeps the half-period, drives both lines low
                    ch_armed[c.chan]   = 1'b0;
                    ch_acc[c.chan]     = '0;
                    ch_phase[c.chan]   = 1'b0;
                    ch_count[c.chan]   = '0;
                    ch_dirbit[c.chan]  = 1'b0;
                    ch_step_ln[c.chan] = 1'b0;
                    ch_dir_ln[c.chan]  = 1'b0;
                    sw[c.chan]         = 1'b1;
                    dw[c.chan]         = 1'b1;
                end
            endcase
        end
        r = '{default: '0};
        for (int i = 0; i < CHANNELS && i < OUT_W; i++)
        begin
            r.step_lv[i] = ch_step_ln[i];
            r.dir_lv[i]  = ch_dir_ln[i];
            r.step_wr[i] = sw[i];
            r.dir_wr[i]  = dw[i];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
        mismatch_cnt++;
        $display("mismatch @%0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    function automatic tone_cmd_t mk(input op_t op, input int unsigned ch,
                                     input int unsigned per, input int unsigned ela,
                                     input bit drain);
        tone_cmd_t c;
        c.op      = op;
        c.chan    = ch[2:0];
        c.period  = per[PER_W-1:0];
        c.elapsed = ela[ELA_W-1:0];
        c.drain   = drain;
        return c;
    endfunction

    // tiny periods most often so channels step often, some mid-range and full-width
    function automatic int unsigned rand_period();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 4);
            4, 5, 6:    return $urandom_range(5, 70000);
            7:          return 32'(ACC_MAX);
            default:    return $urandom() & ACC_MAX;
        endcase
    endfunction

    function automatic int unsigned rand_elapsed();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 3);
            9:             return 'hFFFF;
            default:       return $urandom_range(0, 65535);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // monitor: compare results, then record the command accepted this edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        tone_res_t got;
        tone_res_t want;
        tone_cmd_t c;
        if (rst_n)
        begin
            in_xfer <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.step_lv = m_axis_tdata[4:0];
                got.dir_lv  = m_axis_tdata[9:5];
                got.step_wr = m_axis_tdata[14:10];
                got.dir_wr  = m_axis_tdata[19:15];
                if (level_exp_q.size() == 0)
                    flag_mismatch("result with nothing expected", m_axis_tdata, '0);
                else
                begin
                    want = level_exp_q.pop_front();
                    if (got.step_lv !== want.step_lv)
                        flag_mismatch("step_levels", 24'(got.step_lv), 24'(want.step_lv));
                    if (got.dir_lv !== want.dir_lv)
                        flag_mismatch("dir_levels", 24'(got.dir_lv), 24'(want.dir_lv));
                    if (got.step_wr !== want.step_wr)
                        flag_mismatch("step_written", 24'(got.step_wr), 24'(want.step_wr));
                    if (got.dir_wr !== want.dir_wr)
                        flag_mismatch("dir_written", 24'(got.dir_wr), 24'(want.dir_wr));
                    if (m_axis_tdata[23:20] !== 4'b0)
                        flag_mismatch("pad bits", 24'(m_axis_tdata[23:20]), '0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                c.op      = op_t'(s_axis_tdata[1:0]);
                c.chan    = s_axis_tdata[4:2];
                c.period  = s_axis_tdata[28:5];
                c.elapsed = s_axis_tdata[44:29];
                c.drain   = 1'b0;
                level_exp_q.push_back(bank_step(c));
                in_count <= in_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver: offer the next pending command on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        int unsigned gap;
        tone_cmd_t   c;
        gap = send_gap;
        if (rst_n)
        begin
            // the offered command went through: maybe idle for a burst
            if (in_xfer && !calm && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 19);
            if (s_axis_tvalid && !in_xfer)
                ;   // still waiting for the transfer, hold everything
            else if (gap > 0)
            begin
                gap = gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (cmd_q[0].drain && level_exp_q.size() != 0)
                s_axis_tvalid <= 1'b0;  // pause until the bank has caught up
            else
            begin
                c = cmd_q.pop_front();
                s_axis_tdata  <= {3'b0, c.elapsed, c.period, c.chan, c.op};
                s_axis_tvalid <= 1'b1;
            end
            send_gap <= gap;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall bursts and one long hold that backs up the bank
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        int unsigned stall;
        int unsigned hold;
        stall = rx_stall;
        hold  = hold_left;
        if (rst_n)
        begin
            if (!hold_done && in_count >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold = HOLD_LEN;
            end
            if (hold > 0)
            begin
                hold = hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall = stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
            rx_stall  <= stall;
            hold_left <= hold;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned keep;
        int unsigned blk;
        int unsigned sel;
        int unsigned ch;

        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_armed[i]   = 1'b0;
            ch_half[i]    = '0;
            ch_acc[i]     = '0;
            ch_phase[i]   = 1'b0;
            ch_count[i]   = '0;
            ch_dirbit[i]  = 1'b0;
            ch_step_ln[i] = 1'b0;
            ch_dir_ln[i]  = 1'b0;
        end

        // directed: idle tick, zero period, saturation, out-of-range channels
        cmd_q.push_back(mk(OP_TICK,  0, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_PLAY,  0, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  0, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_PLAY,  1, 32'(ACC_MAX), 0,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  0, 0,            'hFFFF, 1'b0));
        cmd_q.push_back(mk(OP_PLAY,  2, 3,            0,      1'b0));
        cmd_q.push_back(mk(OP_PLAY,  4, 'hABCDE,      0,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  0, 0,            1,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  0, 0,            2,      1'b0));
        cmd_q.push_back(mk(OP_STOP,  0, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  7, 32'(ACC_MAX), 'hFFFF, 1'b0));
        cmd_q.push_back(mk(OP_PLAY,  5, 7,            0,      1'b0));
        cmd_q.push_back(mk(OP_STOP,  7, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_CLEAR, 6, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_CLEAR, 1, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_PLAY,  3, 'h800000,     0,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  0, 0,            'h8000, 1'b0));
        cmd_q.push_back(mk(OP_CLEAR, 4, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_STOP,  3, 0,            0,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  0, 0,            'h7FFF, 1'b0));
        cmd_q.push_back(mk(OP_PLAY,  3, ACC_MAX - 1,  0,      1'b0));
        cmd_q.push_back(mk(OP_TICK,  0, 0,            'hFFFF, 1'b0));

        // random blocks: one channel keeps stepping so sweeps complete,
        // the others see plays, stops and clears around it
        while (cmd_q.size() < ITEMS)
        begin
            keep = $urandom_range(0, CHANNELS - 1);
            blk  = $urandom_range(100, 220);
            cmd_q.push_back(mk(OP_PLAY, keep, $urandom_range(0, 2), 0, 1'b1));
            for (int k = 0; k < blk && cmd_q.size() < ITEMS; k++)
            begin
                sel = $urandom_range(0, 99);
                ch  = $urandom_range(0, 6);
                if (ch >= keep)
                    ch = ch + 1;
                if (sel < 76)
                    cmd_q.push_back(mk(OP_TICK, $urandom_range(0, 7), rand_period(),
                                       rand_elapsed(), 1'b0));
                else if (sel < 88)
                    cmd_q.push_back(mk(OP_PLAY, $urandom_range(0, 7), rand_period(),
                                       rand_elapsed(), 1'b0));
                else if (sel < 94)
                    cmd_q.push_back(mk(OP_STOP, ch, rand_period(), rand_elapsed(), 1'b0));
                else
                    cmd_q.push_back(mk(OP_CLEAR, ch, rand_period(), rand_elapsed(), 1'b0));
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything offered and taken, then every result back
        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (level_exp_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #6000000;
        $display("timeout with %0d results outstanding", level_exp_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
